[rtl/core/positional_list_engine_assert.svh]
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Clocked property checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define PLE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A trigger in one cycle demands an outcome in the next cycle.
`define PLE_ASSERT_NEXT(label, clk, rst_n, trig, outcome, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
        else $error(msg);
`else
`define PLE_ASSERT(label, clk, rst_n, prop, msg)
`define PLE_ASSERT_NEXT(label, clk, rst_n, trig, outcome, msg)
`endif
`endif

[rtl/core/ple_pkg.sv]
// ----------------------------------------------------------------------------
// Positional list engine package
// Command and result payload types, codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Command codes.
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic signed [31:0] t_word;

    // One command transfer.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] position;
        t_word      value;
    } t_item;

    // One result transfer.
    typedef struct packed {
        logic [1:0] status;
        t_word      read_value;
        logic [7:0] list_length;
    } t_result;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic       shift_up;
        logic       shift_down;
        logic       read_sel;
        logic [7:0] pos;
        t_word      value;
    } t_cell_ctrl;

endpackage

[rtl/core/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed words kept in a row of cells, with read, insert
// and delete at a one-based position.
// ----------------------------------------------------------------------------
// Usage: a command transfer (cmd, position, value on i_item) is taken at a
// rising edge where start is high and busy is low. Each command yields one
// result on o_result, marked by o_done for exactly one cycle; the receiver
// has no way to stall it.
// Insert, delete, rejected commands and the unused code: the result appears
// in the cycle after the command, and busy stays low, so one such command
// can be taken every cycle.
// Read within the list: the entry travels down the cell chain's read bus,
// one cell per cycle, toward cell 0. The result is registered from cell 0
// once the entry arrives there, busy is high until the result shows, and
// a new command can be taken in the cycle the result shows.
// Reset clears the length and all control state; list entries are not
// cleared and are defined only once written.
// ----------------------------------------------------------------------------
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
    parameter int DEPTH = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ple_pkg::t_item   i_item,
    output logic             o_done,
    output ple_pkg::t_result o_result
);
    import ple_pkg::*;

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int CMPW = ((CNTW > 8) ? CNTW : 8) + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic            r_state;
    logic            n_state;
    logic [CNTW-1:0] r_count;
    logic [CNTW-1:0] n_count;
    logic [7:0]      r_pos;
    logic [7:0]      n_pos;
    logic [7:0]      r_cnt;
    logic [7:0]      n_cnt;
    logic            r_done;
    logic            n_done;
    t_result         r_result;
    t_result         n_result;
    t_cell_ctrl      w_ctrl;
    logic            w_accept;
    logic [CMPW-1:0] w_pos_x;
    logic [CMPW-1:0] w_cnt_x;
    logic            w_in_list;
    logic            w_ins_ok;
    logic            w_full;
    t_word           w_word [DEPTH];
    t_word           w_rb   [DEPTH];

    // Range checks against the current length.
    assign w_accept  = start && (r_state == S_IDLE);
    assign w_pos_x   = CMPW'(i_item.position);
    assign w_cnt_x   = CMPW'(r_count);
    assign w_in_list = (w_pos_x != '0) && (w_pos_x <= w_cnt_x);
    assign w_ins_ok  = (w_pos_x != '0) && (w_pos_x <= (w_cnt_x + 1'b1));
    assign w_full    = (r_count == CNTW'(DEPTH));

    // Command sequencer.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_result = r_result;
        w_ctrl   = '0;
        w_ctrl.value = i_item.value;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_result.status     = ST_OK;
                    n_result.read_value = '0;
                    case (i_item.cmd)
                        CMD_READ: begin
                            if (w_in_list) begin
                                n_state = S_READ;
                                n_pos   = i_item.position - 8'd1;
                                n_cnt   = i_item.position;
                            end else begin
                                n_result.status = ST_RANGE;
                            end
                        end
                        CMD_INSERT: begin
                            if (!w_ins_ok) begin
                                n_result.status = ST_RANGE;
                            end else if (w_full) begin
                                n_result.status = ST_FULL;
                            end else begin
                                w_ctrl.shift_up = 1'b1;
                                w_ctrl.pos      = i_item.position - 8'd1;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            if (!w_in_list) begin
                                n_result.status = ST_RANGE;
                            end else begin
                                w_ctrl.shift_down = 1'b1;
                                w_ctrl.pos        = i_item.position - 8'd1;
                                n_count           = r_count - 1'b1;
                            end
                        end
                        default: begin
                            n_result.status = ST_OK;
                        end
                    endcase
                    n_result.list_length = 8'(n_count);
                    n_done = (n_state == S_IDLE);
                end
            end
            S_READ: begin
                w_ctrl.read_sel = 1'b1;
                w_ctrl.pos      = r_pos;
                if (r_cnt == 8'd0) begin
                    n_state              = S_IDLE;
                    n_done               = 1'b1;
                    n_result.status      = ST_OK;
                    n_result.read_value  = w_rb[0];
                    n_result.list_length = 8'(r_count);
                end else begin
                    n_cnt = r_cnt - 8'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    // Row of cells; the read bus runs from the top cell down to cell 0.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_word w_lower;
        t_word w_upper;
        t_word w_rb_in;
        if (k == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_word[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_upper = '0;
            assign w_rb_in = '0;
        end else begin : g_mid_hi
            assign w_upper = w_word[k+1];
            assign w_rb_in = w_rb[k+1];
        end
        ple_cell #(
            .INDEX_W (IW),
            .INDEX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .i_rb    (w_rb_in),
            .o_word  (w_word[k]),
            .o_rb    (w_rb[k])
        );
    end

    assign busy     = (r_state == S_READ);
    assign o_done   = r_done;
    assign o_result = r_result;

    // Assertions.
    `PLE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNTW'(DEPTH), "length above depth")
    `PLE_ASSERT(a_done_not_busy, i_clk, i_rst_n, !(r_done && busy), "result while busy")
    `PLE_ASSERT_NEXT(a_fast_result, i_clk, i_rst_n,
                     start && !busy && i_item.cmd != CMD_READ, o_done, "missing result")
    `PLE_ASSERT(a_read_end, i_clk, i_rst_n, $fell(busy) |-> o_done, "read ended without result")
    `PLE_ASSERT(a_count_step, i_clk, i_rst_n,
                !$past(i_rst_n) || r_count == $past(r_count)
                    || r_count == $past(r_count) + 1'b1 || r_count == $past(r_count) - 1'b1,
                "length jumped")

endmodule

[rtl/core/ple_cell.sv]
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry and one stage of the read bus. Shifts its entry
// to or from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int INDEX_W = 7,
    parameter int INDEX   = 0
) (
    input  logic                i_clk,
    input  ple_pkg::t_cell_ctrl i_ctrl,
    input  ple_pkg::t_word      i_lower,
    input  ple_pkg::t_word      i_upper,
    input  ple_pkg::t_word      i_rb,
    output ple_pkg::t_word      o_word,
    output ple_pkg::t_word      o_rb
);
    import ple_pkg::*;

    localparam int CW = (INDEX_W > 8) ? INDEX_W : 8;
    localparam logic [CW-1:0] K = CW'(INDEX);

    logic [CW-1:0] w_pos;
    logic          w_at_pos;
    logic          w_above;
    t_word         r_word;
    t_word         n_word;
    t_word         r_rb;
    t_word         n_rb;

    // Compare this cell's place against the zero-based target position.
    assign w_pos    = CW'(i_ctrl.pos);
    assign w_at_pos = (K == w_pos);
    assign w_above  = (K > w_pos);

    // Entry update: insert moves entries up, delete moves them down.
    always_comb begin
        n_word = r_word;
        if (i_ctrl.shift_up) begin
            if (w_at_pos) begin
                n_word = i_ctrl.value;
            end else if (w_above) begin
                n_word = i_lower;
            end
        end else if (i_ctrl.shift_down) begin
            if (w_at_pos || w_above) begin
                n_word = i_upper;
            end
        end
    end

    // Read bus stage: the selected cell injects its entry, others pass along.
    assign n_rb = (i_ctrl.read_sel && w_at_pos) ? r_word : i_rb;

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_rb   <= n_rb;
    end

    assign o_word = r_word;
    assign o_rb   = r_rb;

endmodule
